// ----- rtl/core/small_assoc_word_cache_random_defines.svh -----
// Assertion macros for the word cache.
// Used by the top level only; needs clock and reset in scope.
`ifndef SMALL_ASSOC_WORD_CACHE_RANDOM_DEFINES_SVH
`define SMALL_ASSOC_WORD_CACHE_RANDOM_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define SAWC_CHECK_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SAWC_CHECK_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/sawc_pkg.sv -----
// Shared constants, types and helper functions of the word cache.
// No dependencies; imported by every module of the block.
`default_nettype none

package sawc_pkg;

   localparam int ADDRESS_W           = 10;
   localparam int WORD_W              = 32;
   localparam int COUNT_W             = 32;
   localparam int SEED_W              = 16;
   localparam int SLOTS_DEFAULT       = 4;
   localparam int STORE_DEPTH_DEFAULT = 1024;

   localparam logic [SEED_W-1:0]  SEED_RESET = 16'd44257;
   localparam logic [SEED_W-1:0]  LFSR_TAPS  = 16'hB400;
   localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_READ = 1'b1;

   // Write strobes from the controller to the slot array.
   typedef struct packed {
      logic word_we;
      logic tag_we;
   } slot_wr_type;

   function automatic logic [SEED_W-1:0] lfsr_step(input logic [SEED_W-1:0] v);
      lfsr_step = v[0] ? ((v >> 1) ^ LFSR_TAPS) : (v >> 1);
   endfunction

   // A zero seed would lock the LFSR, so it is replaced by one.
   function automatic logic [SEED_W-1:0] seed_fix(input logic [SEED_W-1:0] s);
      seed_fix = (s == '0) ? SEED_W'(1) : s;
   endfunction

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
      sat_inc = (v == COUNT_MAX) ? v : v + COUNT_W'(1);
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/sawc_backing_ram.sv -----
// Backing word store: one write port, one read port, registered read data.
// Depends on sawc_pkg for the word width.
`default_nettype none

module sawc_backing_ram import sawc_pkg::*; #(
   parameter int DEPTH = STORE_DEPTH_DEFAULT,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [AW-1:0]     waddr,
   input  wire logic [WORD_W-1:0] wdata,
   input  wire logic [AW-1:0]     raddr,
   output logic      [WORD_W-1:0] rdata
);

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ----- rtl/core/sawc_slots.sv -----
// Cache slot array: tags and words in flops, tag compare and slot read mux.
// Depends on sawc_pkg for slot_wr_type and the word width.
`default_nettype none

module sawc_slots import sawc_pkg::*; #(
   parameter int SLOTS = SLOTS_DEFAULT,
   parameter int TAG_W = $clog2(STORE_DEPTH_DEFAULT),
   localparam int SLOT_W = $clog2(SLOTS)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [TAG_W-1:0]  lookup_tag,
   output logic                   hit,
   output logic      [SLOT_W-1:0] hit_idx,
   input  wire logic [SLOT_W-1:0] rd_idx,
   output logic      [TAG_W-1:0]  rd_tag,
   output logic      [WORD_W-1:0] rd_word,
   input  wire slot_wr_type       wr,
   input  wire logic [SLOT_W-1:0] wr_idx,
   input  wire logic [TAG_W-1:0]  wr_tag,
   input  wire logic [WORD_W-1:0] wr_word
);

   logic [TAG_W-1:0]  tag_ff  [SLOTS];
   logic [WORD_W-1:0] word_ff [SLOTS];

   // Slots are scanned from the top so that the lowest matching slot wins.
   always_comb begin
      hit     = 1'b0;
      hit_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (tag_ff[i] == lookup_tag) begin
            hit     = 1'b1;
            hit_idx = SLOT_W'(i);
         end
      end
   end

   assign rd_tag  = tag_ff[rd_idx];
   assign rd_word = word_ff[rd_idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            tag_ff[i]  <= TAG_W'(i);
            word_ff[i] <= '0;
         end
      end else begin
         if (wr.tag_we) begin
            tag_ff[wr_idx] <= wr_tag;
         end
         if (wr.word_we) begin
            word_ff[wr_idx] <= wr_word;
         end
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/small_assoc_word_cache_random.sv -----
// Fully associative word cache with random replacement in front of a backing
// word store. A load word writes the store and any resident copy; a read word
// returns the slot copy on a hit, or on a miss writes back an LFSR-chosen
// victim slot and fetches the word into it. Loads and hits go to the output
// register, where a result waits; the next word may follow at once unless it
// is stalled. A miss passes the fetch state, as RAM reads are registered. The
// backing store has no reset and no clearing pass; slots reset to addresses
// 0 upward with zero words. STORE_DEPTH and SLOTS are powers of two.
// Depends on sawc_pkg, sawc_slots, sawc_backing_ram and the defines header.
`default_nettype none
`include "small_assoc_word_cache_random_defines.svh"

module small_assoc_word_cache_random import sawc_pkg::*; #(
   parameter int SLOTS       = SLOTS_DEFAULT,
   parameter int STORE_DEPTH = STORE_DEPTH_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic                 req_command,
   input  wire logic [ADDRESS_W-1:0] req_address,
   input  wire logic [WORD_W-1:0]    req_write_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic      [WORD_W-1:0]    rsp_read_data,
   output logic                      rsp_was_hit,
   output logic      [COUNT_W-1:0]   rsp_hit_count,
   output logic      [COUNT_W-1:0]   rsp_fault_count,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [SEED_W-1:0]    csr_replace_seed
);

   localparam int STORE_AW = $clog2(STORE_DEPTH);
   localparam int SLOT_W   = $clog2(SLOTS);

   typedef enum logic {ST_IDLE, ST_FETCH} state_type;

   state_type          state_ff,      state_in;
   logic               rsp_valid_ff,  rsp_valid_in;
   logic [WORD_W-1:0]  rsp_data_ff,   rsp_data_in;
   logic               rsp_hit_ff,    rsp_hit_in;
   logic [COUNT_W-1:0] hit_count_ff,  hit_count_in;
   logic [COUNT_W-1:0] fault_count_ff, fault_count_in;
   logic [SEED_W-1:0]  lfsr_ff,       lfsr_in;
   logic [SLOT_W-1:0]  victim_ff,     victim_in;
   logic [STORE_AW-1:0] addr_ff,      addr_in;

   logic [STORE_AW-1:0] req_index;
   logic                accept;
   logic                is_read;
   logic                lookup_hit;
   logic [SLOT_W-1:0]   lookup_idx;
   logic [SEED_W-1:0]   lfsr_next;
   logic [SLOT_W-1:0]   victim_next;
   logic                csr_write;

   logic [SLOT_W-1:0]   slot_rd_idx;
   logic [STORE_AW-1:0] slot_rd_tag;
   logic [WORD_W-1:0]   slot_rd_word;
   slot_wr_type         slot_wr;
   logic [SLOT_W-1:0]   slot_wr_idx;
   logic [STORE_AW-1:0] slot_wr_tag;
   logic [WORD_W-1:0]   slot_wr_word;

   logic                ram_we;
   logic [STORE_AW-1:0] ram_waddr;
   logic [WORD_W-1:0]   ram_wdata;
   logic [WORD_W-1:0]   ram_rdata;

   if (STORE_AW <= ADDRESS_W) begin : g_index_narrow
      assign req_index = req_address[STORE_AW-1:0];
   end else begin : g_index_wide
      assign req_index = {{(STORE_AW - ADDRESS_W){1'b0}}, req_address};
   end

   assign req_stall   = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept      = req_valid && !req_stall;
   assign is_read     = (req_command == CMD_READ);
   assign lfsr_next   = lfsr_step(lfsr_ff);
   assign victim_next = lfsr_next[SLOT_W-1:0];
   assign csr_ready   = 1'b1;
   assign csr_write   = csr_valid && csr_ready;

   sawc_slots #(
      .SLOTS (SLOTS),
      .TAG_W (STORE_AW)
   ) u_slots (
      .clock      (clock),
      .reset      (reset),
      .lookup_tag (req_index),
      .hit        (lookup_hit),
      .hit_idx    (lookup_idx),
      .rd_idx     (slot_rd_idx),
      .rd_tag     (slot_rd_tag),
      .rd_word    (slot_rd_word),
      .wr         (slot_wr),
      .wr_idx     (slot_wr_idx),
      .wr_tag     (slot_wr_tag),
      .wr_word    (slot_wr_word)
   );

   sawc_backing_ram #(
      .DEPTH (STORE_DEPTH)
   ) u_backing (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (req_index),
      .rdata (ram_rdata)
   );

   // The slot read port serves the hit data or the victim for write-back.
   // A miss writes back the victim while reading the new address; the two
   // never collide because the requested address is not resident.
   always_comb begin
      slot_rd_idx  = lookup_hit ? lookup_idx : victim_next;
      slot_wr      = '0;
      slot_wr_idx  = lookup_idx;
      slot_wr_tag  = addr_ff;
      slot_wr_word = req_write_data;
      ram_we       = 1'b0;
      ram_waddr    = req_index;
      ram_wdata    = req_write_data;
      if (state_ff == ST_FETCH) begin
         slot_wr.word_we = 1'b1;
         slot_wr.tag_we  = 1'b1;
         slot_wr_idx     = victim_ff;
         slot_wr_word    = ram_rdata;
      end else if (accept && !is_read) begin
         ram_we          = 1'b1;
         slot_wr.word_we = lookup_hit;
      end else if (accept && !lookup_hit) begin
         ram_we    = 1'b1;
         ram_waddr = slot_rd_tag;
         ram_wdata = slot_rd_word;
      end
   end

   always_comb begin
      state_in       = state_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_data_in    = rsp_data_ff;
      rsp_hit_in     = rsp_hit_ff;
      hit_count_in   = hit_count_ff;
      fault_count_in = fault_count_ff;
      lfsr_in        = lfsr_ff;
      victim_in      = victim_ff;
      addr_in        = addr_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (is_read && !lookup_hit) begin
                  state_in       = ST_FETCH;
                  fault_count_in = sat_inc(fault_count_ff);
                  lfsr_in        = lfsr_next;
                  victim_in      = victim_next;
                  addr_in        = req_index;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_hit_in   = is_read;
                  rsp_data_in  = is_read ? slot_rd_word : '0;
                  if (is_read) begin
                     hit_count_in = sat_inc(hit_count_ff);
                  end
               end
            end
         end
         ST_FETCH: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            rsp_hit_in   = 1'b0;
            rsp_data_in  = ram_rdata;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // Seed writes are to arrive only while the cache is idle; the block itself does not enforce this.
      if (csr_write) begin
         lfsr_in = seed_fix(csr_replace_seed);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         hit_count_ff   <= '0;
         fault_count_ff <= '0;
         lfsr_ff        <= seed_fix(SEED_RESET);
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         hit_count_ff   <= hit_count_in;
         fault_count_ff <= fault_count_in;
         lfsr_ff        <= lfsr_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_hit_ff  <= rsp_hit_in;
      victim_ff   <= victim_in;
      addr_ff     <= addr_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_data   = rsp_data_ff;
   assign rsp_was_hit     = rsp_hit_ff;
   assign rsp_hit_count   = hit_count_ff;
   assign rsp_fault_count = fault_count_ff;

   `SAWC_CHECK_NOW(a_fetch_out_empty, state_ff == ST_FETCH, !rsp_valid_ff,
                   "output register busy during a miss fetch")
   `SAWC_CHECK_NEXT(a_fetch_delivers, state_ff == ST_FETCH,
                    rsp_valid_ff && !rsp_hit_ff && state_ff == ST_IDLE,
                    "miss fetch did not deliver its word")
   `SAWC_CHECK_NEXT(a_miss_enters_fetch, accept && is_read && !lookup_hit,
                    state_ff == ST_FETCH && fault_count_ff != '0,
                    "read miss did not start a fetch")
   `SAWC_CHECK_NOW(a_one_counter, !$past(reset) && !$stable(hit_count_ff),
                   $stable(fault_count_ff),
                   "hit and fault counters changed together")

endmodule

`default_nettype wire
